// ----- sv/sle_pkg.sv -----
// sle_pkg: shared types and constants for the serial line editor
// no dependencies; imported by sle_ctrl and serial_line_editor_core
package sle_pkg;

    // result kinds
    localparam logic [1:0] KIND_ECHO = 2'd0;
    localparam logic [1:0] KIND_LINE = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;

    // character codes
    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_DEL   = 8'd127;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_NUL   = 8'd0;

    // max_length register
    localparam int unsigned  MAXLEN_W     = 6;
    localparam logic [5:0]   MAXLEN_RESET = 6'd32;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_BS_SPACE,
        S_BS_BACK,
        S_LF,
        S_LINE,
        S_END
    } t_state;

endpackage

// ----- sv/serial_line_editor_core.sv -----
// serial_line_editor_core: top level of the serial line editor
// depends on sle_pkg, sle_store and sle_ctrl
//
//  channel  direction  handshake                  payload
//  rx       in         i_rx_valid / o_rx_ready    i_rx_byte
//  res      out        o_res_valid / i_res_ready  o_kind, o_value, o_last
//  cfg      in         i_cfg_we (no wait)         i_cfg_data (max_length)
//
//  a printable byte or backspace is taken, its echoes follow
//  one per cycle unless the result register stalls; a carriage return
//  echoes CR and LF, then each line byte read from the store port, then an end marker
//  synchronous active-low reset clears the fill count and the sequencer,
//  max_length returns to 32; the store is not cleared
//  a stalled result register holds the sequencer; rx is taken only in idle
module serial_line_editor_core
    import sle_pkg::*;
#(
    parameter int LINE_MAX = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [MAXLEN_W-1:0] i_cfg_data,
    input  logic                i_rx_valid,
    output logic                o_rx_ready,
    input  logic [7:0]          i_rx_byte,
    output logic                o_res_valid,
    input  logic                i_res_ready,
    output logic [1:0]          o_kind,
    output logic [7:0]          o_value,
    output logic                o_last
);

    localparam int CW = $clog2(LINE_MAX);

    logic [MAXLEN_W-1:0] r_max_length;
    logic                st_we;
    logic [CW-1:0]       st_waddr;
    logic [7:0]          st_wdata;
    logic [CW-1:0]       st_raddr;
    logic [7:0]          st_rdata;

    // max_length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length <= MAXLEN_RESET;
        end else if (i_cfg_we) begin
            r_max_length <= i_cfg_data;
        end
    end

    sle_ctrl #(
        .LINE_MAX (LINE_MAX)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_max_length (r_max_length),
        .i_rx_valid   (i_rx_valid),
        .o_rx_ready   (o_rx_ready),
        .i_rx_byte    (i_rx_byte),
        .o_res_valid  (o_res_valid),
        .i_res_ready  (i_res_ready),
        .o_kind       (o_kind),
        .o_value      (o_value),
        .o_last       (o_last),
        .o_st_we      (st_we),
        .o_st_waddr   (st_waddr),
        .o_st_wdata   (st_wdata),
        .o_st_raddr   (st_raddr),
        .i_st_rdata   (st_rdata)
    );

    sle_store #(
        .LINE_MAX (LINE_MAX)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

endmodule

// ----- sv/sle_store.sv -----
// sle_store: line store, one write port and one registered read port
// no package dependency; used by serial_line_editor_core
module sle_store #(
    parameter int LINE_MAX = 32
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [$clog2(LINE_MAX)-1:0] i_waddr,
    input  logic [7:0]                  i_wdata,
    input  logic [$clog2(LINE_MAX)-1:0] i_raddr,
    output logic [7:0]                  o_rdata
);

    logic [7:0] mem [LINE_MAX];
    logic [7:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered
    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/sle_ctrl.sv -----
// sle_ctrl: editing sequencer, fill count and output register
// depends on sle_pkg; drives the sle_store ports
module sle_ctrl
    import sle_pkg::*;
#(
    parameter int LINE_MAX = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [MAXLEN_W-1:0]         i_max_length,
    input  logic                        i_rx_valid,
    output logic                        o_rx_ready,
    input  logic [7:0]                  i_rx_byte,
    output logic                        o_res_valid,
    input  logic                        i_res_ready,
    output logic [1:0]                  o_kind,
    output logic [7:0]                  o_value,
    output logic                        o_last,
    output logic                        o_st_we,
    output logic [$clog2(LINE_MAX)-1:0] o_st_waddr,
    output logic [7:0]                  o_st_wdata,
    output logic [$clog2(LINE_MAX)-1:0] o_st_raddr,
    input  logic [7:0]                  i_st_rdata
);

    localparam int CW = $clog2(LINE_MAX);
    localparam logic [MAXLEN_W-1:0] LIM_MAX = MAXLEN_W'(LINE_MAX);

    t_state         r_state, n_state;
    logic [CW-1:0]  r_fill,  n_fill;
    logic [CW-1:0]  r_idx,   n_idx;
    logic           r_out_valid, n_out_valid;
    logic [1:0]     r_kind,  n_kind;
    logic [7:0]     r_value, n_value;
    logic           r_last,  n_last;

    logic               can_load;
    logic               load;
    logic               rx_acc;
    logic [MAXLEN_W-1:0] limit;
    logic               room;
    logic               last_byte;

    // output slot is free or being emptied this cycle
    assign can_load = !r_out_valid || i_res_ready;
    assign rx_acc   = i_rx_valid && can_load && (r_state == S_IDLE);

    // effective limit, saturated to the store depth
    assign limit = (i_max_length > LIM_MAX) ? LIM_MAX : i_max_length;
    assign room  = ({1'b0, (MAXLEN_W)'(r_fill)} + 7'd1) < {1'b0, limit};

    // current line index is the final stored byte
    assign last_byte = ({1'b0, r_idx} + (CW+1)'(1)) == {1'b0, r_fill};

    // next state and result loading
    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_idx       = r_idx;
        n_kind      = r_kind;
        n_value     = r_value;
        n_last      = r_last;
        load        = 1'b0;
        o_rx_ready  = 1'b0;
        o_st_we     = 1'b0;
        o_st_waddr  = r_fill;
        o_st_wdata  = i_rx_byte;
        case (r_state)
            S_IDLE: begin
                o_rx_ready = can_load;
                if (rx_acc) begin
                    if (i_rx_byte == CH_BS || i_rx_byte == CH_DEL) begin
                        if (r_fill != '0) begin
                            load    = 1'b1;
                            n_kind  = KIND_ECHO;
                            n_value = CH_BS;
                            n_last  = 1'b0;
                            n_fill  = r_fill - CW'(1);
                            n_state = S_BS_SPACE;
                        end
                    end else if (i_rx_byte == CH_CR) begin
                        load    = 1'b1;
                        n_kind  = KIND_ECHO;
                        n_value = CH_CR;
                        n_last  = 1'b0;
                        n_state = S_LF;
                    end else if (room) begin
                        load    = 1'b1;
                        n_kind  = KIND_ECHO;
                        n_value = i_rx_byte;
                        n_last  = 1'b1;
                        o_st_we = 1'b1;
                        n_fill  = r_fill + CW'(1);
                    end
                end
            end
            S_BS_SPACE: begin
                if (can_load) begin
                    load    = 1'b1;
                    n_kind  = KIND_ECHO;
                    n_value = CH_SPACE;
                    n_last  = 1'b0;
                    n_state = S_BS_BACK;
                end
            end
            S_BS_BACK: begin
                if (can_load) begin
                    load    = 1'b1;
                    n_kind  = KIND_ECHO;
                    n_value = CH_BS;
                    n_last  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_LF: begin
                if (can_load) begin
                    load    = 1'b1;
                    n_kind  = KIND_ECHO;
                    n_value = CH_LF;
                    n_last  = 1'b0;
                    n_idx   = '0;
                    n_state = (r_fill == '0) ? S_END : S_LINE;
                end
            end
            S_LINE: begin
                if (can_load) begin
                    load    = 1'b1;
                    n_kind  = KIND_LINE;
                    n_value = i_st_rdata;
                    n_last  = 1'b0;
                    if (last_byte) begin
                        n_state = S_END;
                    end else begin
                        n_idx = r_idx + CW'(1);
                    end
                end
            end
            S_END: begin
                if (can_load) begin
                    load    = 1'b1;
                    n_kind  = KIND_END;
                    n_value = CH_NUL;
                    n_last  = 1'b1;
                    n_fill  = '0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_valid = load || (r_out_valid && !i_res_ready);
    end

    // read ahead at the next index so data lines up with r_idx
    assign o_st_raddr = n_idx;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind  <= n_kind;
            r_value <= n_value;
            r_last  <= n_last;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_kind      = r_kind;
    assign o_value     = r_value;
    assign o_last      = r_last;

    // fill count stays within the store
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_fill} < (CW+1)'(LINE_MAX)))
        else $error("fill count beyond store depth");

    // carriage return always starts the line readout
    a_cr_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rx_acc && i_rx_byte == CH_CR) |=> (r_state == S_LF))
        else $error("carriage return did not start readout");

    // end marker empties the line and returns to idle
    a_end_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_END && can_load) |=> (r_fill == '0 && r_state == S_IDLE))
        else $error("end of line did not clear the line");

    // a final result is only loaded on the way back to idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && n_last) |=> (r_state == S_IDLE))
        else $error("final result loaded outside the last step");

endmodule
